@@ rtl/core/sfcs_pkg.sv @@
package sfcs_pkg;

  // page geometry
  localparam int PAGE_BYTES = 256;
  localparam int PAGE_BITS  = $clog2(PAGE_BYTES);
  localparam int SEG_W      = PAGE_BITS + 1;

  // bundle queue depth
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // request and item operations
  localparam logic [2:0] OP_READ     = 3'd0;
  localparam logic [2:0] OP_WRITE    = 3'd1;
  localparam logic [2:0] OP_SECTOR   = 3'd2;
  localparam logic [2:0] OP_SUBSECT  = 3'd3;
  localparam logic [2:0] OP_BULK     = 3'd4;
  localparam logic [2:0] OP_READ_ID  = 3'd5;
  localparam logic [2:0] OP_WR_BYTE  = 3'd6;
  localparam logic [2:0] OP_BUS_BYTE = 3'd7;

  // result kinds
  localparam logic [2:0] K_SEND    = 3'd0;
  localparam logic [2:0] K_RELEASE = 3'd1;
  localparam logic [2:0] K_READ    = 3'd2;
  localparam logic [2:0] K_NEED    = 3'd3;
  localparam logic [2:0] K_DONE    = 3'd4;
  localparam logic [2:0] K_ID      = 3'd5;

  // flash commands
  localparam logic [7:0] OPC_DATA_READ    = 8'h03;
  localparam logic [7:0] CMD_PP           = 8'h02;
  localparam logic [7:0] CMD_SE           = 8'hD8;
  localparam logic [7:0] CMD_SSE          = 8'h20;
  localparam logic [7:0] CMD_BE           = 8'hC7;
  localparam logic [7:0] OPC_ID_READ      = 8'h9F;
  localparam logic [7:0] OPC_WRITE_ENABLE = 8'h06;
  localparam logic [7:0] OPC_STATUS_READ  = 8'h05;
  localparam logic [7:0] DUMMY            = 8'h00;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  bus_byte;
    logic [7:0]  host_byte;
    logic [23:0] ident;
  } result_t;

  // up to three results caused by one item
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r2;
    result_t    r1;
    result_t    r0;
  } bundle_t;

endpackage

@@ rtl/core/spi_nor_flash_command_sequencer_top.sv @@
// an item's results go through the bundle queue and the output register to the master side
// throughput: one item per cycle on the slave side; one result per cycle on the master side
// while m_tready is high; an item's results leave one by one, and a four-bundle queue decouples
// the two sides, and the slave side stalls only when that queue is full
// reset: synchronous, sequencer returns to idle, queue and output register empty
module spi_nor_flash_command_sequencer_top
  import sfcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // address[23:0], length[39:24], data_byte[47:40]
  input  logic [2:0]  s_tuser,   // operation[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // bus_byte[7:0], host_byte[15:8], ident[39:16]
  output logic [2:0]  m_tuser,   // kind[2:0]
  output logic        m_tlast
);

  logic    take, push, pop, empty, full;
  bundle_t bundle, head;
  result_t res;

  assign s_tready = !full;
  assign take     = s_tvalid && s_tready;

  sfcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .operation (s_tuser),
    .address   (s_tdata[23:0]),
    .length    (s_tdata[39:24]),
    .data_byte (s_tdata[47:40]),
    .push      (push),
    .bundle    (bundle)
  );

  sfcs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (bundle),
    .pop   (pop),
    .head  (head),
    .empty (empty),
    .full  (full)
  );

  sfcs_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .valid (m_tvalid),
    .ready (m_tready),
    .res   (res),
    .last  (m_tlast)
  );

  assign m_tdata = {res.ident, res.host_byte, res.bus_byte};
  assign m_tuser = res.kind;

  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("bundle pushed into full queue");

  // no pop from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("bundle popped from empty queue");

  // a pushed bundle makes the queue non-empty next cycle
  a_push_seen: assert property (@(posedge clk) disable iff (rst) push |=> !empty || $past(pop))
    else $error("pushed bundle lost");

endmodule

@@ rtl/core/sfcs_front.sv @@
module sfcs_front
  import sfcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [2:0]  operation,
  input  logic [23:0] address,
  input  logic [15:0] length,
  input  logic [7:0]  data_byte,
  output logic        push,
  output bundle_t     bundle
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_WREN     = 3'd1;
  localparam logic [2:0] PH_WEL_POLL = 3'd2;
  localparam logic [2:0] PH_CMD      = 3'd3;
  localparam logic [2:0] PH_READ     = 3'd4;
  localparam logic [2:0] PH_WAIT_W   = 3'd5;
  localparam logic [2:0] PH_WRITE    = 3'd6;
  localparam logic [2:0] PH_WIP_POLL = 3'd7;

  logic [2:0]       phase, phase_next;
  logic [2:0]       req, req_next;
  logic [23:0]      faddr, faddr_next;
  logic [15:0]      remain, remain_next;
  logic [SEG_W-1:0] seg, seg_next;
  logic [2:0]       fbi, fbi_next;
  logic [23:0]      id_acc, id_next;

  result_t    res [3];
  logic [1:0] n;

  // command byte of a request
  function automatic logic [7:0] cmd_of(input logic [2:0] r);
    logic [7:0] c;
    case (r)
      OP_READ:    c = OPC_DATA_READ;
      OP_WRITE:   c = CMD_PP;
      OP_SECTOR:  c = CMD_SE;
      OP_SUBSECT: c = CMD_SSE;
      OP_BULK:    c = CMD_BE;
      default:    c = OPC_ID_READ;
    endcase
    return c;
  endfunction

  // sequencer step: next state and results for one item
  always_comb begin
    logic [SEG_W-1:0] room;
    logic [2:0]       final_idx;
    logic [2:0]       nxt;
    logic             start_cmd;
    logic             start_poll;
    logic [2:0]       poll_ph;
    logic             fin;
    phase_next  = phase;
    req_next    = req;
    faddr_next  = faddr;
    remain_next = remain;
    seg_next    = seg;
    fbi_next    = fbi;
    id_next     = id_acc;
    n           = 2'd0;
    start_cmd   = 1'b0;
    start_poll  = 1'b0;
    poll_ph     = PH_WIP_POLL;
    fin         = 1'b0;
    room        = '0;
    final_idx   = 3'd0;
    nxt         = 3'd0;
    for (int i = 0; i < 3; i++) res[i] = '0;

    if (operation <= OP_READ_ID) begin
      if (phase == PH_IDLE) begin
        req_next    = operation;
        faddr_next  = address;
        remain_next = length;
        seg_next    = '0;
        fbi_next    = 3'd0;
        id_next     = '0;
        if (operation == OP_READ || operation == OP_READ_ID) begin
          start_cmd = 1'b1;
        end else if (operation == OP_WRITE && length == 16'd0) begin
          fin = 1'b1;
        end else begin
          phase_next = PH_WREN;
          res[0].bus_byte = OPC_WRITE_ENABLE;
          n = 2'd1;
        end
      end
    end else if (operation == OP_WR_BYTE) begin
      if (phase == PH_WAIT_W) begin
        phase_next = PH_WRITE;
        res[0].bus_byte = data_byte;
        n = 2'd1;
      end
    end else if (phase != PH_IDLE && phase != PH_WAIT_W) begin
      case (phase)
        PH_WREN: begin
          res[0].kind = K_RELEASE;
          n = 2'd1;
          start_poll = 1'b1;
          poll_ph = PH_WEL_POLL;
        end
        PH_WEL_POLL, PH_WIP_POLL: begin
          if (fbi < 3'd2) begin
            fbi_next = fbi + 3'd1;
            n = 2'd1;
          end else begin
            res[0].kind = K_RELEASE;
            n = 2'd1;
            if (phase == PH_WEL_POLL) begin
              if (data_byte[1]) begin
                start_cmd = 1'b1;
              end else begin
                start_poll = 1'b1;
                poll_ph = PH_WEL_POLL;
              end
            end else if (data_byte[0]) begin
              start_poll = 1'b1;
            end else if (req == OP_WRITE && remain != 16'd0) begin
              phase_next = PH_WREN;
              fbi_next = 3'd0;
              res[1].bus_byte = OPC_WRITE_ENABLE;
              n = 2'd2;
            end else begin
              fin = 1'b1;
            end
          end
        end
        PH_CMD: begin
          final_idx = (req == OP_BULK) ? 3'd0 : 3'd3;
          if (req == OP_READ_ID && fbi >= 3'd1) id_next = {id_acc[15:0], data_byte};
          if (fbi < final_idx) begin
            nxt = fbi + 3'd1;
            fbi_next = nxt;
            n = 2'd1;
            if (req != OP_READ_ID) begin
              case (nxt)
                3'd1:    res[0].bus_byte = faddr[23:16];
                3'd2:    res[0].bus_byte = faddr[15:8];
                default: res[0].bus_byte = faddr[7:0];
              endcase
            end
          end else if (req == OP_READ) begin
            if (remain != 16'd0) begin
              phase_next = PH_READ;
              n = 2'd1;
            end else begin
              res[0].kind = K_RELEASE;
              n = 2'd1;
              fin = 1'b1;
            end
          end else if (req == OP_WRITE) begin
            phase_next = PH_WAIT_W;
            res[0].kind = K_NEED;
            n = 2'd1;
          end else if (req == OP_READ_ID) begin
            res[0].kind = K_RELEASE;
            res[1].kind = K_ID;
            res[1].ident = id_next;
            n = 2'd2;
            phase_next = PH_IDLE;
            fbi_next = 3'd0;
          end else begin
            res[0].kind = K_RELEASE;
            n = 2'd1;
            start_poll = 1'b1;
          end
        end
        PH_READ: begin
          res[0].kind = K_READ;
          res[0].host_byte = data_byte;
          n = 2'd1;
          remain_next = remain - 16'd1;
          if (remain_next != 16'd0) begin
            n = 2'd2;
          end else begin
            res[1].kind = K_RELEASE;
            n = 2'd2;
            fin = 1'b1;
          end
        end
        PH_WRITE: begin
          seg_next = seg - SEG_W'(1);
          remain_next = remain - 16'd1;
          faddr_next = faddr + 24'd1;
          if (seg_next != '0) begin
            phase_next = PH_WAIT_W;
            res[0].kind = K_NEED;
            n = 2'd1;
          end else begin
            res[0].kind = K_RELEASE;
            n = 2'd1;
            start_poll = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // frame openers and the closing done
    if (start_cmd) begin
      if (req_next == OP_WRITE) begin
        room = SEG_W'(PAGE_BYTES) - {1'b0, faddr_next[PAGE_BITS-1:0]};
        seg_next = ({8'd0, remain_next} < 24'(room)) ? SEG_W'(remain_next) : room;
      end
      phase_next = PH_CMD;
      fbi_next = 3'd0;
      res[n].bus_byte = cmd_of(req_next);
      n = n + 2'd1;
    end
    if (start_poll) begin
      phase_next = poll_ph;
      fbi_next = 3'd0;
      res[n].bus_byte = OPC_STATUS_READ;
      n = n + 2'd1;
    end
    if (fin) begin
      phase_next = PH_IDLE;
      fbi_next = 3'd0;
      res[n].kind = K_DONE;
      n = n + 2'd1;
    end
  end

  assign push       = take && (n != 2'd0);
  assign bundle.cnt = n;
  assign bundle.r0  = res[0];
  assign bundle.r1  = res[1];
  assign bundle.r2  = res[2];

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      req    <= '0;
      faddr  <= '0;
      remain <= '0;
      seg    <= '0;
      fbi    <= '0;
      id_acc <= '0;
    end else if (take) begin
      phase  <= phase_next;
      req    <= req_next;
      faddr  <= faddr_next;
      remain <= remain_next;
      seg    <= seg_next;
      fbi    <= fbi_next;
      id_acc <= id_next;
    end
  end

endmodule

@@ rtl/core/sfcs_queue.sv @@
module sfcs_queue
  import sfcs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t din,
  input  logic    pop,
  output bundle_t head,
  output logic    empty,
  output logic    full
);

  bundle_t           mem [QDEPTH];
  logic [QPTR_W-1:0] wp, rp;
  logic [QPTR_W:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign head  = mem[rp];

  // bundle storage
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

@@ rtl/core/sfcs_back.sv @@
module sfcs_back
  import sfcs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  bundle_t head,
  input  logic    empty,
  output logic    pop,
  output logic    valid,
  input  logic    ready,
  output result_t res,
  output logic    last
);

  logic [1:0] idx;
  logic       load;
  logic       fin;
  result_t    pick;

  // pick the next result of the head bundle
  always_comb begin
    case (idx)
      2'd0:    pick = head.r0;
      2'd1:    pick = head.r1;
      default: pick = head.r2;
    endcase
  end

  assign load = !empty && (!valid || ready);
  assign fin  = (idx + 2'd1) == head.cnt;
  assign pop  = load && fin;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else begin
      if (load) begin
        valid <= 1'b1;
        idx   <= fin ? 2'd0 : idx + 2'd1;
      end else if (ready) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res  <= pick;
      last <= fin;
    end
  end

endmodule
